[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ste_pkg.sv]
// Shared types, constants and functions of the separator tokenizer.
// Depends on nothing.
package ste_pkg;

  localparam int BYTE_W       = 8;
  localparam int SEP_W        = 64;
  localparam int NUM_SEP_REGS = 4;
  localparam int SEP_IDX_W    = $clog2(NUM_SEP_REGS);
  localparam int CFG_IDX_W    = 8;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W    = CMD_PTR_W + 1;
  localparam int STEP_W       = 3;

  localparam logic [STEP_W-1:0] EXPAND_LEN = 3'd6;

  localparam logic [BYTE_W-1:0] CH_LBRACK      = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_RBRACK      = 8'h5d;
  localparam logic [BYTE_W-1:0] CH_ZERO        = 8'h30;
  localparam logic [BYTE_W-1:0] CH_X           = 8'h78;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH   = 8'h5c;
  localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'h57;  // 'a' minus ten

  // What the back end emits for one request before an optional token end.
  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_CHAR,
    BODY_EXPAND
  } body_t;

  typedef struct packed {
    body_t             body;
    logic [BYTE_W-1:0] ch;    // plain character, or escape code to expand
    logic              tend;  // close the token after the body
  } cmd_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {4'b0, n};
    end else begin
      r = HEX_ALPHA_BASE + {4'b0, n};
    end
    return r;
  endfunction

  // Character at position step of the text [0xHH].
  function automatic logic [BYTE_W-1:0] expand_char(input logic [BYTE_W-1:0] code,
                                                    input logic [STEP_W-1:0] step);
    logic [BYTE_W-1:0] r;
    case (step)
      3'd0:    r = CH_LBRACK;
      3'd1:    r = CH_ZERO;
      3'd2:    r = CH_X;
      3'd3:    r = hex_digit(code[7:4]);
      3'd4:    r = hex_digit(code[3:0]);
      default: r = CH_RBRACK;
    endcase
    return r;
  endfunction

endpackage

[rtl/ste_in_if.sv]
// Input channel of the tokenizer: one byte per request.
// Depends on ste_pkg.
interface ste_in_if import ste_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_string;

  modport source(output valid, output in_byte, output end_of_string, input ready);
  modport sink(input valid, input in_byte, input end_of_string, output ready);
endinterface

[rtl/ste_out_if.sv]
// Output channel of the tokenizer: one token character or token end per request.
// Depends on ste_pkg.
interface ste_out_if import ste_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              char_valid;
  logic              token_end;
  logic              last;

  modport source(output valid, output out_char, output char_valid, output token_end,
                 output last, input ready);
  modport sink(input valid, input out_char, input char_valid, input token_end,
               input last, output ready);
endinterface

[rtl/ste_front.sv]
// Front end: accepts bytes, tracks token and backslash state, classifies each byte
// into a command for the back end. Depends on ste_pkg.
module ste_front import ste_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [BYTE_W-1:0]                   in_byte,
  input  logic                                end_of_string,
  input  logic [NUM_SEP_REGS-1:0][SEP_W-1:0]  sep_mask,
  input  logic                                cmd_full,
  output logic                                push,
  output cmd_t                                cmd
);

  logic pending_backslash;
  logic token_nonempty;
  logic pending_backslash_next;
  logic token_nonempty_next;
  logic is_sep;
  logic accept;
  logic [BYTE_W-1:0] lcode;
  logic [BYTE_W-1:0] rcode;
  logic body_ne;

  function automatic logic [BYTE_W-1:0] letter_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    case (b)
      8'h6e:   r = 8'h0a;  // n
      8'h74:   r = 8'h09;  // t
      8'h76:   r = 8'h0b;  // v
      8'h62:   r = 8'h08;  // b
      8'h72:   r = 8'h0d;  // r
      8'h66:   r = 8'h0c;  // f
      8'h61:   r = 8'h07;  // a
      8'h22:   r = 8'h22;  // double quote
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] raw_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    case (b)
      8'h0a, 8'h09, 8'h0b, 8'h08, 8'h0d, 8'h0c, 8'h07, 8'h22: r = b;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign is_sep   = sep_mask[in_byte[BYTE_W-1:SEP_IDX_W*3]][in_byte[SEP_IDX_W*3-1:0]];
  assign lcode    = letter_code(in_byte);
  assign rcode    = raw_code(in_byte);

  always_comb begin
    cmd.body = BODY_NONE;
    cmd.ch   = in_byte;
    cmd.tend = 1'b0;
    body_ne  = 1'b0;
    pending_backslash_next = 1'b0;
    token_nonempty_next    = token_nonempty;
    if (is_sep) begin
      cmd.tend            = token_nonempty;
      token_nonempty_next = 1'b0;
    end else begin
      priority if (pending_backslash && lcode != '0) begin
        cmd.body = BODY_EXPAND;
        cmd.ch   = lcode;
      end else if (in_byte == CH_BACKSLASH) begin
        pending_backslash_next = 1'b1;
      end else if (rcode != '0) begin
        cmd.body = BODY_EXPAND;
        cmd.ch   = rcode;
      end else begin
        cmd.body = BODY_CHAR;
      end
      body_ne             = (cmd.body != BODY_NONE);
      token_nonempty_next = token_nonempty || body_ne;
      // end of string closes the token right after this byte
      if (end_of_string) begin
        cmd.tend               = token_nonempty_next;
        pending_backslash_next = 1'b0;
        token_nonempty_next    = 1'b0;
      end
    end
  end

  // drop items that produce nothing
  assign push = accept && (cmd.body != BODY_NONE || cmd.tend);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_backslash <= 1'b0;
      token_nonempty    <= 1'b0;
    end else if (accept) begin
      pending_backslash <= pending_backslash_next;
      token_nonempty    <= token_nonempty_next;
    end
  end

endmodule

[rtl/ste_cmd_fifo.sv]
// Short command queue between front and back end.
// Depends on ste_pkg.
module ste_cmd_fifo import ste_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic full
);

  cmd_t                 store [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign head      = store[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CMD_CNT_W'(CMD_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ste_back.sv]
// Back end: walks each command one result per cycle into the output register
// while the output is not stalled. Depends on ste_pkg.
module ste_back import ste_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_char,
  output logic              char_valid,
  output logic              token_end,
  output logic              last
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] body_len;
  logic [STEP_W-1:0] total;
  logic              is_last;
  logic              load;
  logic              in_body;
  logic [BYTE_W-1:0] res_char;

  always_comb begin
    unique case (cmd.body)
      BODY_CHAR:   body_len = 3'd1;
      BODY_EXPAND: body_len = EXPAND_LEN;
      default:     body_len = '0;
    endcase
  end

  assign total   = body_len + {{(STEP_W-1){1'b0}}, cmd.tend};
  assign is_last = (step == total - 1'b1);
  assign in_body = (step < body_len);
  assign load    = cmd_valid && (!out_valid || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    if (!in_body) begin
      res_char = '0;
    end else if (cmd.body == BODY_CHAR) begin
      res_char = cmd.ch;
    end else begin
      res_char = expand_char(cmd.ch, step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      step      <= is_last ? '0 : step + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char   <= res_char;
      char_valid <= in_body;
      token_end  <= !in_body;
      last       <= is_last;
    end
  end

endmodule

[rtl/separator_tokenizer_escape_expand_unit.sv]
// Separator-set tokenizer with escape expansion, top level.
// Throughput, unless the output stalls: one byte per cycle while each byte gives at most
//   one result; an escape gives six or seven results, emitted one per cycle by the back
//   end sequencer. Accepted bytes pass the command queue before the output register.
// Reset (rst, synchronous): clears separator masks, token/backslash state, queue, output.
// Depends on ste_pkg, ste_in_if, ste_out_if, ste_front, ste_cmd_fifo, ste_back.
module separator_tokenizer_escape_expand_unit import ste_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ste_in_if.sink               in_ch,
  ste_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEP_W-1:0]     cfg_data
);

  // Separator set, 256 flags in four 64-bit registers.
  logic [NUM_SEP_REGS-1:0][SEP_W-1:0] sep_mask;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic cmd_full;
  logic cmd_not_empty;

  // Write a mask register; drop writes beyond the last register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_mask <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_SEP_REGS)) begin
      sep_mask[cfg_index[SEP_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Classify each byte and keep token state; hold input while the queue is full.
  ste_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.in_byte),
    .end_of_string (in_ch.end_of_string),
    .sep_mask      (sep_mask),
    .cmd_full      (cmd_full),
    .push          (push),
    .cmd           (front_cmd)
  );

  // Decouple classification from expansion so either side can stall.
  ste_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .not_empty (cmd_not_empty),
    .full      (cmd_full)
  );

  // Emit characters, expansions and token ends; advance while the output drains.
  ste_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head_cmd),
    .cmd_valid  (cmd_not_empty),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_char   (out_ch.out_char),
    .char_valid (out_ch.char_valid),
    .token_end  (out_ch.token_end),
    .last       (out_ch.last)
  );

endmodule

[rtl/ste_checker.sv]
// Port-level checks of the tokenizer output, bound to the top level.
// Depends on ste_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ste_checker import ste_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_char,
  input logic              char_valid,
  input logic              token_end,
  input logic              last
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // a stalled request keeps its payload
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_char) && $stable(last))
  // reset empties the output register
  `ASSERT_NEXT_ALWAYS(a_rst_clear, clk, rst, !out_valid)
  // a token end carries no character and always closes the byte's results
  `ASSERT_IMPLIES(a_tend_form, clk, rst, out_valid && !char_valid, token_end && last && out_char == '0)
  // a character never also closes a token
  `ASSERT_IMPLIES(a_char_form, clk, rst, out_valid && char_valid, !token_end)

endmodule

bind separator_tokenizer_escape_expand_unit ste_checker u_ste_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .char_valid (out_ch.char_valid),
  .token_end  (out_ch.token_end),
  .last       (out_ch.last)
);

[tb/sv/tb_separator_tokenizer_escape_expand_unit.sv]
`timescale 1ns / 100ps
// Self-checking bench for the separator-set tokenizer with escape expansion.
// Depends on ste_pkg, ste_in_if, ste_out_if and the top level of the unit.
module tb_separator_tokenizer_escape_expand_unit;
  import ste_pkg::*;

  // One result request as it leaves the unit.
  typedef struct packed {
    logic [BYTE_W-1:0] out_char;
    logic              char_valid;
    logic              token_end;
    logic              last;
  } tok_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One line of the directed table: either a register write or an input request.
  // Rows not marked from_model carry up to two typed results.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SEP_W-1:0]     reg_data;
    logic [BYTE_W-1:0]    in_byte;
    logic                 eos;
    logic                 from_model;
    logic [1:0]           n_typed;
    tok_result_t          t0;
    tok_result_t          t1;
  } dir_row_t;

  typedef enum logic [1:0] {MASK_SPARSE, MASK_NONE, MASK_ALL, MASK_NOISE} mask_mode_t;
  typedef enum logic [1:0] {RX_STEADY, RX_JITTER, RX_CHOKE} rx_mode_t;

  localparam logic [CFG_IDX_W-1:0] SEP_REG0     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] SEP_REG1     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] SEP_REG2     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] SEP_REG3     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_NONE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP  = 8'hff;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  // Raw escape bytes and the letters that name them after a backslash, packed bytewise.
  localparam logic [63:0] RAW_ESC_SET = 64'h0a090b080d0c0722;
  localparam logic [63:0] ESC_LETTERS = {"ntvbrfa", CH_QUOTE};

  localparam tok_result_t TOKEN_CLOSE = '{out_char: 8'h00, char_valid: 1'b0,
                                         token_end: 1'b1, last: 1'b1};

  localparam int DRAIN_CYCLES = 8;     // margin for the command queue and the back end sequencer
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int HOLD_AT      = 100;   // input requests before the long receiver hold-off
  localparam int LONG_HOLD    = 80;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SEP_W-1:0]     cfg_data;

  ste_in_if  in_ch();
  ste_out_if out_ch();

  separator_tokenizer_escape_expand_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tokenizer state mirrored by the bench.
  logic [SEP_W-1:0] sep_set [NUM_SEP_REGS];
  logic             bs_pending;
  logic             tok_open;

  tok_result_t       step_results[$];   // results of the request just tokenized
  tok_result_t       token_results_q[$]; // results still owed by the unit, oldest first
  logic [BYTE_W-1:0] sep_bytes[$];       // bytes in the current separator set
  dir_row_t          dir_table[$];

  int fail_cnt    = 0;
  int in_count    = 0;
  int burst_left  = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_sep(input logic [BYTE_W-1:0] b);
    return sep_set[b[7:6]][b[5:0]];
  endfunction

  function automatic logic is_raw_esc(input logic [BYTE_W-1:0] b);
    case (b)
      8'h0a, 8'h09, 8'h0b, 8'h08, 8'h0d, 8'h0c, 8'h07, CH_QUOTE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Escape code named by a letter after a backslash, zero for any other byte.
  function automatic logic [BYTE_W-1:0] esc_code(input logic [BYTE_W-1:0] b);
    case (b)
      "n":      return 8'h0a;
      "t":      return 8'h09;
      "v":      return 8'h0b;
      "b":      return 8'h08;
      "r":      return 8'h0d;
      "f":      return 8'h0c;
      "a":      return 8'h07;
      CH_QUOTE: return CH_QUOTE;
      default:  return 8'h00;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'b0, n} : 8'h61 + {4'b0, n} - 8'd10;
  endfunction

  function automatic void put_char(input logic [BYTE_W-1:0] c);
    step_results.push_back('{out_char: c, char_valid: 1'b1, token_end: 1'b0, last: 1'b0});
    tok_open = 1'b1;
  endfunction

  // Spell an escape code as [0xhh].
  function automatic void spell_code(input logic [BYTE_W-1:0] code);
    put_char("[");
    put_char("0");
    put_char("x");
    put_char(hex_char(code[7:4]));
    put_char(hex_char(code[3:0]));
    put_char("]");
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] b);
    if (b == CH_BACKSLASH) begin
      bs_pending = 1'b1;
    end else if (is_raw_esc(b)) begin
      spell_code(b);
    end else begin
      put_char(b);
    end
  endfunction

  // Drop any held backslash; close the token only if it carries characters.
  function automatic void close_tok();
    bs_pending = 1'b0;
    if (tok_open) begin
      step_results.push_back('{out_char: 8'h00, char_valid: 1'b0, token_end: 1'b1,
                               last: 1'b0});
    end
    tok_open = 1'b0;
  endfunction

  function automatic void tokenize_byte(input logic [BYTE_W-1:0] b, input logic eos);
    logic [BYTE_W-1:0] code;
    step_results.delete();
    // Separators win over escapes, even right after a backslash.
    if (is_sep(b)) begin
      close_tok();
    end else if (bs_pending) begin
      bs_pending = 1'b0;
      code = esc_code(b);
      if (code != 8'h00) begin
        spell_code(code);
      end else begin
        scan_byte(b);
      end
    end else begin
      scan_byte(b);
    end
    if (eos) begin
      close_tok();
    end
    if (step_results.size() != 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Table helpers
  // ---------------------------------------------------------------------------

  function automatic tok_result_t chr(input logic [BYTE_W-1:0] c, input logic lst);
    return '{out_char: c, char_valid: 1'b1, token_end: 1'b0, last: lst};
  endfunction

  // n_typed of -1 leaves the results to the predictor.
  function automatic dir_row_t row_req(input logic [BYTE_W-1:0] b, input logic eos,
                                       input int n_typed = -1,
                                       input tok_result_t t0 = '0,
                                       input tok_result_t t1 = '0);
    dir_row_t r;
    r            = '0;
    r.kind       = ROW_REQ;
    r.in_byte    = b;
    r.eos        = eos;
    r.from_model = (n_typed < 0);
    r.n_typed    = (n_typed < 0) ? 2'd0 : n_typed[1:0];
    r.t0         = t0;
    r.t1         = t1;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [SEP_W-1:0] data);
    dir_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.reg_index = idx;
    r.reg_data  = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Mostly short bursts; now and then a long one with no gaps at all.
  function automatic int new_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
  endfunction

  // Offer one request at the falling edge and hold it until it is taken.
  // Returns at a falling edge.
  task automatic send_req(input logic [BYTE_W-1:0] b, input logic eos,
                          input int n_typed = -1,
                          input tok_result_t t0 = '0, input tok_result_t t1 = '0);
    in_ch.valid         = 1'b1;
    in_ch.in_byte       = b;
    in_ch.end_of_string = eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    in_count++;
    // Always advance the mirrored state, even when the row types its results.
    tokenize_byte(b, eos);
    if (n_typed < 0) begin
      foreach (step_results[k]) token_results_q.push_back(step_results[k]);
    end else begin
      if (n_typed > 0) token_results_q.push_back(t0);
      if (n_typed > 1) token_results_q.push_back(t1);
    end
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = new_burst();
    end
  endtask

  // Drop valid, wait for every owed result, then let the pipeline run dry.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (token_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Single-cycle register write; the unit is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEP_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx < NUM_SEP_REGS) begin
      sep_set[idx[SEP_IDX_W-1:0]] = data;
    end
  endtask

  task automatic program_masks(input mask_mode_t mode);
    logic [SEP_W-1:0]  m [NUM_SEP_REGS];
    logic [BYTE_W-1:0] b;
    int                r;
    settle();
    for (r = 0; r < NUM_SEP_REGS; r++) begin
      case (mode)
        MASK_NONE:  m[r] = '0;
        MASK_ALL:   m[r] = '1;
        MASK_NOISE: m[r] = {$urandom, $urandom};
        default:    m[r] = '0;
      endcase
    end
    if (mode == MASK_SPARSE) begin
      // Keep space as a separator and add a few random bytes.
      b = CH_SPACE;
      m[b[7:6]][b[5:0]] = 1'b1;
      repeat (3) begin
        b = BYTE_W'($urandom_range(1, 255));
        m[b[7:6]][b[5:0]] = 1'b1;
      end
    end
    for (r = 0; r < NUM_SEP_REGS; r++) begin
      write_reg(CFG_IDX_W'(r), m[r]);
    end
    // An index past the last register must not disturb the set.
    write_reg(CFG_IDX_W'($urandom_range(NUM_SEP_REGS, 255)), {$urandom, $urandom});
    sep_bytes.delete();
    for (r = 1; r < 256; r++) begin
      if (is_sep(r[7:0])) sep_bytes.push_back(r[7:0]);
    end
  endtask

  function automatic logic rand_eos();
    return ($urandom_range(0, 11) == 0);
  endfunction

  // Mostly word text with escapes mixed in; the rest is random bytes.
  task automatic run_random(input int n_items);
    int                sent;
    int                pick;
    logic [BYTE_W-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_req(CH_BACKSLASH, rand_eos());
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          b = ESC_LETTERS[8 * $urandom_range(0, 7) +: 8];
        end else if (pick < 75) begin
          b = CH_BACKSLASH;
        end else begin
          b = BYTE_W'($urandom_range(1, 255));
        end
        send_req(b, rand_eos());
        sent += 2;
      end else begin
        if (pick < 50) begin
          b = BYTE_W'($urandom_range(8'h61, 8'h7a));
        end else if (pick < 60) begin
          b = RAW_ESC_SET[8 * $urandom_range(0, 7) +: 8];
        end else if (pick < 78 && sep_bytes.size() != 0) begin
          b = sep_bytes[$urandom_range(0, sep_bytes.size() - 1)];
        end else begin
          b = BYTE_W'($urandom_range(1, 255));
        end
        send_req(b, rand_eos());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.end_of_string = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    for (i = 0; i < NUM_SEP_REGS; i++) sep_set[i] = '0;
    bs_pending = 1'b0;
    tok_open   = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst        = 1'b0;
    burst_left = new_burst();

    // Directed part. Masks start at their reset value of zero, so nothing separates.
    dir_table.push_back(row_req("A", 1'b0, 1, chr("A", 1'b1)));
    dir_table.push_back(row_req(8'hff, 1'b1, 2, chr(8'hff, 1'b0), TOKEN_CLOSE));
    dir_table.push_back(row_req(8'h01, 1'b1, 2, chr(8'h01, 1'b0), TOKEN_CLOSE));
    // Double backslash, then end of string on an empty token: no output.
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b1, 0));
    // Backslash letter, backslash before a raw escape, backslash before a plain byte.
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req("n", 1'b0));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req(8'h0a, 1'b0));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req("q", 1'b0));
    // Escape plus token end in one request: the seven-result case.
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req("a", 1'b1));
    // Backslash left hanging when the string ends: dropped, token closed.
    dir_table.push_back(row_req("Z", 1'b0, 1, chr("Z", 1'b1)));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b1, 1, TOKEN_CLOSE));
    // Separators: space, comma, newline, 'n', 0x80 and 0xff. Out-of-range indexes ignored.
    dir_table.push_back(row_cfg(SEP_REG0, 64'h0000_1001_0000_0400));
    dir_table.push_back(row_cfg(SEP_REG1, 64'h0000_4000_0000_0000));
    dir_table.push_back(row_cfg(SEP_REG2, 64'h0000_0000_0000_0001));
    dir_table.push_back(row_cfg(SEP_REG3, 64'h8000_0000_0000_0000));
    dir_table.push_back(row_cfg(REG_IDX_NONE, '1));
    dir_table.push_back(row_cfg(REG_IDX_TOP, '1));
    dir_table.push_back(row_req("B", 1'b0, 1, chr("B", 1'b1)));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req(CH_SPACE, 1'b0, 1, TOKEN_CLOSE));
    dir_table.push_back(row_req(CH_SPACE, 1'b0, 0));        // empty token suppressed
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req("n", 1'b0, 0));             // separator after a backslash
    dir_table.push_back(row_req(8'h0a, 1'b0, 0));           // escape byte that separates
    dir_table.push_back(row_req(8'hff, 1'b0, 0));
    dir_table.push_back(row_req(8'h80, 1'b1, 0));
    dir_table.push_back(row_req("E", 1'b1, 2, chr("E", 1'b0), TOKEN_CLOSE));
    dir_table.push_back(row_req(CH_BACKSLASH, 1'b0, 0));
    dir_table.push_back(row_req(8'h09, 1'b1));

    foreach (dir_table[k]) begin
      if (dir_table[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_table[k].reg_index, dir_table[k].reg_data);
      end else begin
        send_req(dir_table[k].in_byte, dir_table[k].eos,
                 dir_table[k].from_model ? -1 : int'(dir_table[k].n_typed),
                 dir_table[k].t0, dir_table[k].t1);
      end
    end

    // Random part across several separator sets, the empty and the full set among them.
    program_masks(MASK_SPARSE);
    run_random(60);
    program_masks(MASK_NONE);
    run_random(50);
    program_masks(MASK_SPARSE);
    run_random(60);
    program_masks(MASK_ALL);
    run_random(20);
    program_masks(MASK_NOISE);
    run_random(50);
    program_masks(MASK_SPARSE);
    run_random(60);

    settle();
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off to back the unit up
  // ---------------------------------------------------------------------------

  rx_mode_t rx_mode  = RX_STEADY;
  int       seg_left = 0;
  int       hold_left = 0;
  logic     held_once = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready = 1'b1;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (!held_once && in_count >= HOLD_AT) begin
      // Hold off long enough that the command queue fills and the input stalls.
      held_once    = 1'b1;
      hold_left    = LONG_HOLD - 1;
      out_ch.ready = 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(16, 80);
      end
      seg_left--;
      case (rx_mode)
        RX_STEADY: out_ch.ready = 1'b1;
        RX_JITTER: out_ch.ready = ($urandom_range(0, 3) != 0);
        default:   out_ch.ready = ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted result against the oldest owed one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    tok_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (token_results_q.size() == 0) begin
        $error("result with none owed: out_char %h char_valid %b token_end %b last %b",
               out_ch.out_char, out_ch.char_valid, out_ch.token_end, out_ch.last);
        fail_cnt++;
      end else begin
        want = token_results_q.pop_front();
        if (out_ch.out_char !== want.out_char) begin
          $error("out_char: expected %h, actual %h", want.out_char, out_ch.out_char);
          fail_cnt++;
        end
        if (out_ch.char_valid !== want.char_valid) begin
          $error("char_valid: expected %b, actual %b", want.char_valid, out_ch.char_valid);
          fail_cnt++;
        end
        if (out_ch.token_end !== want.token_end) begin
          $error("token_end: expected %b, actual %b", want.token_end, out_ch.token_end);
          fail_cnt++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_ch.last);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no request moves on either side for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[separator_tokenizer_escape_expand_unit.f]
+incdir+rtl
rtl/ste_pkg.sv
rtl/ste_in_if.sv
rtl/ste_out_if.sv
rtl/ste_front.sv
rtl/ste_cmd_fifo.sv
rtl/ste_back.sv
rtl/separator_tokenizer_escape_expand_unit.sv
rtl/ste_checker.sv
tb/sv/tb_separator_tokenizer_escape_expand_unit.sv
